@@ rtl/core/trle_pkg.sv @@
`timescale 1ns / 1ps

package trle_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PIX_W       = 32;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned BPP_W       = 3;
    localparam int unsigned DIM_W       = 16;
    localparam int unsigned REM_W       = 32;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned OUT_DATA_W  = 40;

    localparam logic [BPP_W-1:0]  BPP_RESET       = 3'd4;
    localparam logic [BPP_W-1:0]  BPP_MIN         = 3'd1;
    localparam logic [BPP_W-1:0]  BPP_MAX         = 3'd4;
    localparam logic [DIM_W-1:0]  DIM_RESET       = 16'd1;
    localparam logic [BYTE_W-1:0] HDR_REPEAT_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_LEN_MASK    = 8'h7F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP    = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [BPP_W-1:0] bpp;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CNT_W-1:0] count;
        logic             done;
    } t_result;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

endpackage

@@ rtl/core/trle_front.sv @@
`timescale 1ns / 1ps

module trle_front import trle_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_start_of_image,
    output logic              o_push,
    output t_result           o_result
);

    logic              r_expect, n_expect;
    logic              r_repeat, n_repeat;
    logic [CNT_W-1:0]  r_raw, n_raw;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [PIX_W-1:0]  r_gather, n_gather;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [REM_W-1:0]  r_rem, n_rem;

    logic [BPP_W-1:0]  w_pix_bytes;
    logic [REM_W-1:0]  w_area;
    logic [PIX_W-1:0]  w_gather;
    logic              w_last_byte;
    logic              w_clamp;
    logic [CNT_W-1:0]  w_count;
    logic [REM_W-1:0]  w_rem_dec;
    logic [CNT_W-1:0]  w_raw_dec;
    logic              w_alive;
    logic              w_header;

    always_comb begin
        if (i_cfg.bpp < BPP_MIN) begin
            w_pix_bytes = BPP_MIN;
        end else if (i_cfg.bpp > BPP_MAX) begin
            w_pix_bytes = BPP_MAX;
        end else begin
            w_pix_bytes = i_cfg.bpp;
        end
    end

    assign w_area      = {{(REM_W-DIM_W){1'b0}}, i_cfg.width}
                       * {{(REM_W-DIM_W){1'b0}}, i_cfg.height};
    assign w_gather    = r_gather | ({{(PIX_W-BYTE_W){1'b0}}, i_data_byte} << {r_idx, 3'b000});
    assign w_last_byte = (({1'b0, r_idx} + 3'd1) >= w_pix_bytes);
    // The repeat run is cut to the pixels left only when fewer than a full run remain.
    assign w_clamp     = (r_rem[REM_W-1:CNT_W] == '0) && (r_rem[CNT_W-1:0] < r_len);
    assign w_count     = r_repeat ? (w_clamp ? r_rem[CNT_W-1:0] : r_len) : 8'd1;
    assign w_rem_dec   = r_rem - {{(REM_W-CNT_W){1'b0}}, w_count};
    assign w_raw_dec   = r_raw - 8'd1;
    assign w_alive     = i_start_of_image ? ((i_cfg.width != '0) && (i_cfg.height != '0))
                                          : (r_rem != '0);
    assign w_header    = i_start_of_image | r_expect;

    always_comb begin
        n_expect = r_expect;
        n_repeat = r_repeat;
        n_raw    = r_raw;
        n_idx    = r_idx;
        n_gather = r_gather;
        n_len    = r_len;
        n_rem    = r_rem;
        o_push   = 1'b0;
        o_result.pixel = w_gather;
        o_result.count = w_count;
        o_result.done  = (w_rem_dec == '0);

        if (i_accept) begin
            if (i_start_of_image) begin
                n_expect = 1'b1;
                n_repeat = 1'b0;
                n_raw    = '0;
                n_idx    = '0;
                n_gather = '0;
                n_len    = '0;
                n_rem    = w_area;
            end
            if (w_alive) begin
                if (w_header) begin
                    n_repeat = ((i_data_byte & HDR_REPEAT_MASK) != '0);
                    n_len    = (i_data_byte & HDR_LEN_MASK) + 8'd1;
                    n_raw    = (i_data_byte & HDR_LEN_MASK) + 8'd1;
                    n_expect = 1'b0;
                    n_idx    = '0;
                    n_gather = '0;
                end else if (!w_last_byte) begin
                    n_idx    = r_idx + 2'd1;
                    n_gather = w_gather;
                end else begin
                    o_push   = 1'b1;
                    n_rem    = w_rem_dec;
                    n_raw    = w_raw_dec;
                    if (r_repeat || (w_raw_dec == '0)) begin
                        n_expect = 1'b1;
                    end
                    n_idx    = '0;
                    n_gather = '0;
                    if (w_rem_dec == '0) begin
                        n_expect = 1'b1;
                        n_repeat = 1'b0;
                        n_raw    = '0;
                        n_len    = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect <= 1'b1;
            r_repeat <= 1'b0;
            r_raw    <= '0;
            r_idx    <= '0;
            r_gather <= '0;
            r_len    <= '0;
            r_rem    <= '0;
        end else begin
            r_expect <= n_expect;
            r_repeat <= n_repeat;
            r_raw    <= n_raw;
            r_idx    <= n_idx;
            r_gather <= n_gather;
            r_len    <= n_len;
            r_rem    <= n_rem;
        end
    end

endmodule

@@ rtl/core/trle_queue.sv @@
`timescale 1ns / 1ps

module trle_queue import trle_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_data,
    input  logic          i_pop,
    output t_queue_status o_status,
    output t_result       o_data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

    t_result            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0]  r_count, n_count;
    logic               w_push;
    logic               w_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_data         = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && o_status.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/core/trle_back.sv @@
`timescale 1ns / 1ps

module trle_back import trle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_result i_q_data,
    output logic    o_pop,
    input  logic    i_tready,
    output logic    o_tvalid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    // The output register takes a new result whenever it is empty or being drained.
    assign o_pop    = i_q_valid && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_result = r_result;

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

@@ rtl/core/tga_rle_pixel_decoder.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Signals                            Contents
// s_axis    in   tvalid, tready, tdata[7:0], tuser  compressed byte, start of image
// m_axis    out  tvalid, tready, tdata[39:0], tlast pixel and run length, image done
// cfg       in   wr_en, index[1:0], wdata[15:0]     pixel size, width, height
//
// One byte is taken in every cycle while the queue is not full. A byte that completes
// a pixel is written into a two-entry queue and from there into the output register.
// The image area is formed by one 16 by 16 multiplier when a start of image is seen.
// Reset is synchronous and active low; it clears the decoder and empties the queue.
// Input ready drops only while the queue holds two results.

module tga_rle_pixel_decoder import trle_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side. tdata: data_byte [7:0]. tuser: start_of_image.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,
    input  logic                  i_s_axis_tuser,
    // Master side. tdata: pixel_value [31:0], repeat_count [39:32]. tlast: image_done.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg          r_cfg;
    t_queue_status w_q_status;
    t_result       w_front_result;
    t_result       w_q_data;
    t_result       w_out_result;
    logic          w_front_push;
    logic          w_pop;
    logic          w_accept;

    // Configuration registers. Writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bpp    <= BPP_RESET;
            r_cfg.width  <= DIM_RESET;
            r_cfg.height <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BPP: begin
                    r_cfg.bpp <= i_cfg_wdata[BPP_W-1:0];
                end
                CFG_WIDTH: begin
                    r_cfg.width <= i_cfg_wdata[DIM_W-1:0];
                end
                CFG_HEIGHT: begin
                    r_cfg.height <= i_cfg_wdata[DIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The front end never stalls on its own; it waits only for queue space.
    assign o_s_axis_tready = !w_q_status.full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    trle_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (w_accept),
        .i_data_byte      (i_s_axis_tdata),
        .i_start_of_image (i_s_axis_tuser),
        .o_push           (w_front_push),
        .o_result         (w_front_result)
    );

    trle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_front_push),
        .i_data   (w_front_result),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_data   (w_q_data)
    );

    trle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_status.valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .i_tready  (i_m_axis_tready),
        .o_tvalid  (o_m_axis_tvalid),
        .o_result  (w_out_result)
    );

    assign o_m_axis_tdata = {w_out_result.count, w_out_result.pixel};
    assign o_m_axis_tlast = w_out_result.done;

endmodule
